// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh - shared assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/clr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_pkg - command line recognizer package
// Keyword table, field widths and the control word fed along the cell row.
// ----------------------------------------------------------------------------
package clr_pkg;

    localparam int NUM_PATTERNS    = 9;
    localparam int STORED_PATTERNS = 9;
    localparam int NUM_ACTIVE      = (NUM_PATTERNS < STORED_PATTERNS) ?
                                     NUM_PATTERNS : STORED_PATTERNS;
    localparam int MAX_PAT_LEN     = 11;
    localparam int PAT_IDX_W       = 4;
    localparam int PROG_W          = 4;
    localparam int CODE_W          = 4;
    localparam int SLOT_W          = 2;

    localparam logic [7:0]        SPACE_CHAR = 8'h20;
    localparam logic [CODE_W-1:0] CODE_NONE  = '0;

    localparam logic [SLOT_W-1:0] SLOT_SENDER  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_COMMAND = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_ARG     = 2'd2;

    // text right-justified: first character in the highest used byte
    localparam logic [MAX_PAT_LEN*8-1:0] PAT_TEXT [STORED_PATTERNS] = '{
        "> AT", "> RTB", "> START", "> PARAM", "> WAYPOINT",
        "> PING", "> DATA", "> STOP", "> OPERATION"
    };
    localparam logic [PROG_W-1:0] PAT_LEN [STORED_PATTERNS] = '{
        4'd4, 4'd5, 4'd7, 4'd7, 4'd10, 4'd6, 4'd6, 4'd6, 4'd11
    };

    typedef struct packed {
        logic       enable;   // word accepted this cycle
        logic       clear;    // last word of the line
        logic [7:0] ch;
    } clr_ctrl_t;

    function automatic logic [PROG_W-1:0] pat_len(input logic [PAT_IDX_W-1:0] idx);
        logic [PROG_W-1:0] len;
        len = '0;
        if (int'(idx) < STORED_PATTERNS)
            len = PAT_LEN[idx];
        return len;
    endfunction

    function automatic logic [7:0] pat_char(input logic [PAT_IDX_W-1:0] idx,
                                            input logic [PROG_W-1:0]    pos);
        logic [MAX_PAT_LEN*8-1:0] txt;
        logic [PROG_W-1:0]        back;
        logic [PROG_W+2:0]        bit_pos;
        txt = '0;
        if (int'(idx) < STORED_PATTERNS)
            txt = PAT_TEXT[idx];
        back    = pat_len(idx) - pos - 4'd1;
        bit_pos = {back, 3'b000};
        return txt[bit_pos +: 8];
    endfunction

endpackage

// ===== rtl/clr_match_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_match_cell - one keyword matcher of the row
// Match counter plus sticky found flag; passes the lowest found code on.
// ----------------------------------------------------------------------------
module clr_match_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  clr_pkg::clr_ctrl_t              ctrl,
    input  logic [clr_pkg::PAT_IDX_W-1:0]   pat_idx,
    input  logic [clr_pkg::CODE_W-1:0]      code_in,
    output logic [clr_pkg::CODE_W-1:0]      code_out
);

    logic [clr_pkg::PROG_W-1:0] prog_reg, prog_next;
    logic                       found_reg, found_next;
    logic [clr_pkg::PROG_W-1:0] prog_adv;
    logic                       hit, restart, complete, found_now;

    always_comb
    begin
        hit       = (ctrl.ch == clr_pkg::pat_char(pat_idx, prog_reg));
        restart   = (ctrl.ch == clr_pkg::pat_char(pat_idx, '0));
        prog_adv  = hit ? (prog_reg + 4'd1) : (restart ? 4'd1 : 4'd0);
        complete  = (prog_adv == clr_pkg::pat_len(pat_idx));
        found_now = found_reg | complete;

        prog_next  = prog_reg;
        found_next = found_reg;
        if (ctrl.enable)
        begin
            if (ctrl.clear)
            begin
                prog_next  = '0;
                found_next = 1'b0;
            end
            else
            begin
                prog_next  = complete ? '0 : prog_adv;
                found_next = found_now;
            end
        end

        // lower cells win
        if (code_in != clr_pkg::CODE_NONE)
            code_out = code_in;
        else if (found_now)
            code_out = clr_pkg::CODE_W'(pat_idx) + 4'd1;
        else
            code_out = clr_pkg::CODE_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            prog_reg  <= prog_next;
            found_reg <= found_next;
        end
    end

endmodule

// ===== rtl/clr_word_tagger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_word_tagger - word slot tagging
// Counts the first two spaces of a line; later spaces are argument text.
// ----------------------------------------------------------------------------
module clr_word_tagger
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  clr_pkg::clr_ctrl_t             ctrl,
    output logic [clr_pkg::SLOT_W-1:0]     word_slot,
    output logic                           is_separator
);

    logic [clr_pkg::SLOT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        word_slot    = cnt_reg;
        is_separator = (ctrl.ch == clr_pkg::SPACE_CHAR) && (cnt_reg != clr_pkg::SLOT_ARG);
        cnt_next     = cnt_reg;
        if (ctrl.enable)
        begin
            if (ctrl.clear)
                cnt_next = clr_pkg::SLOT_SENDER;
            else if (is_separator)
                cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= clr_pkg::SLOT_SENDER;
        else
            cnt_reg <= cnt_next;
    end

endmodule

// ===== rtl/command_line_recognizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_recognizer_top - keyword search and word tagging of text lines
//
// Input stream: one byte of a text line per word, tlast on the line's last
// byte. Output stream: one word per input word, tagged with its slot (sender,
// command, argument) and a separator flag; tlast repeats the line end, and on
// that word tdata carries the code of the lowest keyword found (0 for none).
// A row of identical matcher cells, one per keyword, updates every byte; the
// found code is handed from cell to cell, lowest index winning.
// Result: registered into the output register in the cycle after accept.
// Throughput: one byte per cycle unless the receiver stalls; limited by the
// output register, which takes a new word in the same cycle the old one leaves.
// Reset: all counters, found flags and the output register clear; the first
// line starts in the sender slot. A line end clears counters and found flags.
// Stall: when the receiver holds m_axis_tready low, the result is held and
// s_axis_tready drops until it is taken; no byte is lost or repeated.
// ----------------------------------------------------------------------------
module command_line_recognizer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // end_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] command_code, [7:4] zero
    output logic [2:0]  m_axis_tuser,   // [1:0] word_slot, [2] is_separator
    output logic        m_axis_tlast    // line_done
);

    clr_pkg::clr_ctrl_t ctrl;
    logic               accept;

    // code chain along the row: entry i feeds cell i
    logic [clr_pkg::CODE_W-1:0] code_chain [clr_pkg::NUM_ACTIVE+1];

    logic [clr_pkg::SLOT_W-1:0] slot;
    logic                       sep;
    logic [clr_pkg::CODE_W-1:0] code;

    logic                       out_valid_reg, out_valid_next;
    logic [clr_pkg::CODE_W-1:0] out_code_reg;
    logic [clr_pkg::SLOT_W-1:0] out_slot_reg;
    logic                       out_sep_reg;
    logic                       out_last_reg;

    // output register frees itself in the cycle it is read
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign ctrl.enable = accept;
    assign ctrl.clear  = s_axis_tlast;
    assign ctrl.ch     = s_axis_tdata;

    assign code_chain[0] = clr_pkg::CODE_NONE;

    for (genvar i = 0; i < clr_pkg::NUM_ACTIVE; i++)
    begin : g_cell
        clr_match_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .pat_idx  (clr_pkg::PAT_IDX_W'(i)),
            .code_in  (code_chain[i]),
            .code_out (code_chain[i+1])
        );
    end

    clr_word_tagger u_tagger
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .word_slot    (slot),
        .is_separator (sep)
    );

    // code reported only on the line's last byte
    assign code = s_axis_tlast ? code_chain[clr_pkg::NUM_ACTIVE] : clr_pkg::CODE_NONE;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_code_reg <= clr_pkg::CODE_NONE;
            out_slot_reg <= clr_pkg::SLOT_SENDER;
            out_sep_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_code_reg <= code;
            out_slot_reg <= slot;
            out_sep_reg  <= sep;
            out_last_reg <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_code_reg};
    assign m_axis_tuser  = {out_sep_reg, out_slot_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/clr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_checker - port-level checks for the command line recognizer
// Bound to the top level; sees its ports only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clr_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast
);

    logic s_accept;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // stalled result holds
    `AST_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // empty output register never blocks the input
    `AST_IMPL(a_ready, !m_axis_tvalid, s_axis_tready)
    // every accepted byte gives a result next cycle, line end and separator follow it
    `AST_NEXT(a_result, s_accept, m_axis_tvalid && (m_axis_tlast == $past(s_axis_tlast)) && (!m_axis_tuser[2] || ($past(s_axis_tdata) == clr_pkg::SPACE_CHAR)))
    // code only on line end
    `AST_IMPL(a_code, m_axis_tvalid && !m_axis_tlast, m_axis_tdata == 8'h00)
    // a separator never lies in the argument slot
    `AST_IMPL(a_sep, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] != clr_pkg::SLOT_ARG)

endmodule

bind command_line_recognizer_top clr_checker u_clr_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the command line recognizer
// Text lines go in one byte per word, with tlast on the last byte. A
// local keyword scanner predicts the slot, separator flag, line end and
// keyword code of each word, and the monitor compares every output word
// with it. The sender runs in random bursts, and the receiver stalls on a
// rotating pattern. Directed lines come first, then random lines that are
// mostly built around keywords.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_BYTES = 1350;
    localparam int NUM_KEYWORDS = 9;

    typedef struct {
        bit [7:0] ch;
        bit       eol;
        bit       hold;   // wait for every pending result before sending
    } line_byte_t;

    typedef struct packed {
        logic [clr_pkg::SLOT_W-1:0] slot;
        logic                       sep;
        logic                       done;
        logic [clr_pkg::CODE_W-1:0] code;
    } byte_tag_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    string kw_table [NUM_KEYWORDS] = '{
        "> AT", "> RTB", "> START", "> PARAM", "> WAYPOINT",
        "> PING", "> DATA", "> STOP", "> OPERATION"
    };

    // scanner state
    int                         kw_progress [NUM_KEYWORDS];
    bit [NUM_KEYWORDS-1:0]      kw_found = '0;
    logic [clr_pkg::SLOT_W-1:0] word_idx = clr_pkg::SLOT_SENDER;

    line_byte_t line_byte_q [$];
    byte_tag_t  byte_tag_q  [$];
    bit [7:0]   line_buf    [$];

    line_byte_t drv_item;
    byte_tag_t  want;
    bit         in_take   = 1'b0;
    bit         out_take  = 1'b0;
    int         burst_left = 0;
    int         gap_left   = 0;
    bit [15:0]  rdy_pat    = '1;
    int         rdy_cnt    = 0;
    int         stuck      = 0;
    int         err_count  = 0;

    command_line_recognizer_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Exact substring search per keyword; '>' occurs only at the head of
    // each keyword, so a mismatch restarts at 1 on '>' and at 0 otherwise.
    function automatic byte_tag_t scan_byte(input bit [7:0] ch, input bit eol);
        byte_tag_t tag;
        int        pos;
        int        len;
        tag.slot = word_idx;
        tag.sep  = 1'b0;
        tag.done = eol;
        tag.code = clr_pkg::CODE_NONE;
        for (int k = 0; k < clr_pkg::NUM_ACTIVE; k++)
        begin
            len = kw_table[k].len();
            pos = kw_progress[k];
            if (pos >= len)
                pos = 0;
            if (ch == 8'(kw_table[k][pos]))
                pos++;
            else
                pos = (ch == 8'(kw_table[k][0])) ? 1 : 0;
            if (pos == len)
            begin
                kw_found[k] = 1'b1;
                pos = 0;
            end
            kw_progress[k] = pos;
        end
        // only the first two spaces split words
        if (ch == clr_pkg::SPACE_CHAR && word_idx != clr_pkg::SLOT_ARG)
        begin
            tag.sep  = 1'b1;
            word_idx = word_idx + 1'b1;
        end
        if (eol)
        begin
            for (int k = clr_pkg::NUM_ACTIVE - 1; k >= 0; k--)
                if (kw_found[k])
                    tag.code = clr_pkg::CODE_W'(k + 1);
            for (int k = 0; k < NUM_KEYWORDS; k++)
                kw_progress[k] = 0;
            kw_found = '0;
            word_idx = clr_pkg::SLOT_SENDER;
        end
        return tag;
    endfunction

    function automatic bit [7:0] rand_char();
        bit [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: c = 8'($urandom_range(65, 90));   // upper case
            6:                c = 8'h3E;                       // '>'
            7:                c = clr_pkg::SPACE_CHAR;
            8:                c = 8'($urandom_range(48, 57));  // digit
            default:          c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    task automatic push_line(input bit hold);
        line_byte_t item;
        foreach (line_buf[i])
        begin
            item.ch   = line_buf[i];
            item.eol  = (i == line_buf.size() - 1);
            item.hold = hold && (i == 0);
            line_byte_q.push_back(item);
        end
    endtask

    task automatic push_text(input string txt);
        line_buf.delete();
        for (int i = 0; i < txt.len(); i++)
            line_buf.push_back(8'(txt[i]));
        push_line(1'b0);
    endtask

    // whole keyword, a cut-off prefix, or one with a damaged character
    task automatic add_keyword();
        int k;
        int len;
        int bad;
        k   = $urandom_range(0, NUM_KEYWORDS - 1);
        len = kw_table[k].len();
        bad = -1;
        case ($urandom_range(0, 9))
            0, 1: len = $urandom_range(1, len - 1);
            2:    bad = $urandom_range(1, len - 1);
            default: ;
        endcase
        for (int i = 0; i < len; i++)
            line_buf.push_back((i == bad) ? rand_char() : 8'(kw_table[k][i]));
    endtask

    task automatic make_line();
        line_buf.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12))
                line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 4))
            line_buf.push_back(rand_char());
        if ($urandom_range(0, 5) != 0)
            line_buf.push_back(clr_pkg::SPACE_CHAR);
        if ($urandom_range(0, 4) != 0)
            add_keyword();
        if ($urandom_range(0, 2) == 0)
            add_keyword();
        if ($urandom_range(0, 3) != 0)
            line_buf.push_back(clr_pkg::SPACE_CHAR);
        repeat ($urandom_range(0, 8))
            line_buf.push_back(rand_char());
        if ($urandom_range(0, 4) == 0)
            add_keyword();
        if (line_buf.size() == 0)
            line_buf.push_back(rand_char());
    endtask

    // driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
        end
        else if (!s_axis_tvalid || in_take)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (line_byte_q.size() == 0 ||
                     (line_byte_q[0].hold && byte_tag_q.size() != 0))
            begin
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                drv_item = line_byte_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= drv_item.ch;
                s_axis_tlast  <= drv_item.eol;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 24);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // receiver: rotating ready pattern, reloaded when rdy_cnt runs out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rdy_cnt == 0)
            begin
                rdy_cnt = 48;
                case ($urandom_range(0, 3))
                    0:       rdy_pat = '1;
                    1:       rdy_pat = 16'($urandom);
                    2:       rdy_pat = 16'($urandom | $urandom);
                    default: rdy_pat = 16'($urandom & $urandom);
                endcase
            end
            rdy_cnt--;
            m_axis_tready <= rdy_pat[0];
            rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
        end
    end

    // Monitor. Bus signals only move at the rising edge, so the values at
    // the falling edge are the ones taken at the next rising edge.
    always @(negedge clk)
    begin
        in_take  = 1'b0;
        out_take = 1'b0;
        if (rst_n)
        begin
            in_take  = s_axis_tvalid && s_axis_tready;
            out_take = m_axis_tvalid && m_axis_tready;
            if (in_take)
                byte_tag_q.push_back(scan_byte(s_axis_tdata, s_axis_tlast));
            if (out_take)
            begin
                if (byte_tag_q.size() == 0)
                begin
                    if (err_count < 10)
                        $display("%0t: unexpected word tdata=%h tuser=%b tlast=%b",
                                 $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    err_count++;
                end
                else
                begin
                    want = byte_tag_q.pop_front();
                    if (m_axis_tdata !== {{(8 - clr_pkg::CODE_W){1'b0}}, want.code} ||
                        m_axis_tuser[clr_pkg::SLOT_W-1:0] !== want.slot ||
                        m_axis_tuser[clr_pkg::SLOT_W] !== want.sep ||
                        m_axis_tlast !== want.done)
                    begin
                        if (err_count < 10)
                            $display({"%0t: mismatch code %h/%h slot %0d/%0d",
                                      " sep %b/%b done %b/%b (expected/actual)"},
                                     $realtime, want.code, m_axis_tdata,
                                     want.slot, m_axis_tuser[clr_pkg::SLOT_W-1:0],
                                     want.sep, m_axis_tuser[clr_pkg::SLOT_W],
                                     want.done, m_axis_tlast);
                        err_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word accepted on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_take || out_take)
                stuck = 0;
            else
                stuck++;
            if (stuck >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int sent;
        bit first_line;
        for (int k = 0; k < NUM_KEYWORDS; k++)
            kw_progress[k] = 0;

        // keyword closing on the last byte, with both separators
        push_text("a b> AT");
        // all-zero and all-one bytes as one-byte lines without keywords
        line_buf.delete();
        line_buf.push_back(8'h00);
        push_line(1'b0);
        line_buf.delete();
        line_buf.push_back(8'hFF);
        push_line(1'b0);
        // '>' inside a partial match restarts the search
        push_text(">> RTB");
        // two keywords: the lower table entry wins over the earlier one
        push_text("> PING> AT");

        sent       = 0;
        first_line = 1'b1;
        while (sent < RANDOM_BYTES)
        begin
            make_line();
            sent += line_buf.size();
            push_line(first_line || ($urandom_range(0, 11) == 0));
            first_line = 1'b0;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (line_byte_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (byte_tag_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        err_count += byte_tag_q.size();
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
